// File: hdl/fdfr_pkg.sv
// ----------------------------------------------------------------------------
// fdfr_pkg
// Shared constants and types for the flag-delimited frame receiver.
// ----------------------------------------------------------------------------
package fdfr_pkg;

  localparam int unsigned MAX_FRAME = 40;
  localparam int unsigned CNT_W     = 6;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_FRAME - 2);
  localparam logic [CNT_W-1:0] CNT_SAT   = CNT_W'(MAX_FRAME - 1);

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DIR_ERR = 3'd1;
  localparam logic [2:0] ST_CHN_ERR = 3'd2;
  localparam logic [2:0] ST_CRC_ERR = 3'd3;
  localparam logic [2:0] ST_LEN_ERR = 3'd4;

  localparam logic [7:0] REG_DIRECTION = 8'd0;
  localparam logic [7:0] REG_CHANNEL   = 8'd1;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] command;
    logic [7:0] argument;
    logic [5:0] payload_length;
  } res_t;

endpackage

// File: hdl/fdfr_crc8.sv
// ----------------------------------------------------------------------------
// fdfr_crc8
// CRC-16/XMODEM update by one byte, MSB first.
// ----------------------------------------------------------------------------
module fdfr_crc8 (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ fdfr_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// File: hdl/fdfr_frame.sv
// ----------------------------------------------------------------------------
// fdfr_frame
// Frame tracking state, field capture, CRC accumulation and closing checks.
// ----------------------------------------------------------------------------
module fdfr_frame (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic [7:0]           direction_code,
  input  logic [7:0]           channel_code,
  output logic                 res_valid,
  output fdfr_pkg::res_t       res
);

  logic                       in_frame_r, in_frame_nxt;
  logic [fdfr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]                crc_r, crc_nxt, crc_upd;
  logic [7:0]                 older_r, older_nxt;
  logic [7:0]                 newer_r, newer_nxt;
  logic                       dir_ok_r, dir_ok_nxt;
  logic                       chn_ok_r, chn_ok_nxt;
  logic [7:0]                 len_r, len_nxt;
  logic [7:0]                 cmd_r, cmd_nxt;
  logic [7:0]                 arg_r, arg_nxt;
  logic                       is_flag;
  logic [8:0]                 expect_cnt;
  logic [2:0]                 status;

  fdfr_crc8 u_crc (
    .crc_in  (crc_r),
    .data_in (older_r),
    .crc_out (crc_upd)
  );

  assign is_flag    = (rx_byte == fdfr_pkg::FLAG_BYTE);
  assign res_valid  = in_frame_r && is_flag && (cnt_r != '0);
  assign expect_cnt = {1'b0, len_r} + 9'd5;

  always_comb begin
    if ((cnt_r > fdfr_pkg::CNT_LIMIT) || (cnt_r < fdfr_pkg::CNT_W'(3))) begin
      status = fdfr_pkg::ST_LEN_ERR;
    end else if (!dir_ok_r) begin
      status = fdfr_pkg::ST_DIR_ERR;
    end else if (!chn_ok_r) begin
      status = fdfr_pkg::ST_CHN_ERR;
    end else if ({3'b000, cnt_r} != expect_cnt) begin
      status = fdfr_pkg::ST_LEN_ERR;
    end else if (crc_r != {older_r, newer_r}) begin
      status = fdfr_pkg::ST_CRC_ERR;
    end else begin
      status = fdfr_pkg::ST_OK;
    end
    res.status         = status;
    res.command        = ((status == fdfr_pkg::ST_OK) && (len_r >= 8'd1)) ? cmd_r : 8'h00;
    res.argument       = ((status == fdfr_pkg::ST_OK) && (len_r >= 8'd2)) ? arg_r : 8'h00;
    res.payload_length = (len_r > 8'd63) ? 6'd63 : len_r[5:0];
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    cnt_nxt      = cnt_r;
    crc_nxt      = crc_r;
    older_nxt    = older_r;
    newer_nxt    = newer_r;
    dir_ok_nxt   = dir_ok_r;
    chn_ok_nxt   = chn_ok_r;
    len_nxt      = len_r;
    cmd_nxt      = cmd_r;
    arg_nxt      = arg_r;
    if (step) begin
      if (is_flag && (!in_frame_r || (cnt_r == '0))) begin
        in_frame_nxt = 1'b1;
        cnt_nxt      = '0;
        crc_nxt      = 16'h0000;
        older_nxt    = 8'h00;
        newer_nxt    = 8'h00;
        dir_ok_nxt   = 1'b0;
        chn_ok_nxt   = 1'b0;
        len_nxt      = 8'h00;
        cmd_nxt      = 8'h00;
        arg_nxt      = 8'h00;
      end else if (in_frame_r && is_flag) begin
        in_frame_nxt = 1'b0;
      end else if (in_frame_r) begin
        if (cnt_r >= fdfr_pkg::CNT_LIMIT) begin
          cnt_nxt = fdfr_pkg::CNT_SAT;
        end else begin
          if (cnt_r >= fdfr_pkg::CNT_W'(2)) begin
            crc_nxt = crc_upd;
          end
          older_nxt = newer_r;
          newer_nxt = rx_byte;
          case (cnt_r)
            fdfr_pkg::CNT_W'(0): dir_ok_nxt = (rx_byte == direction_code);
            fdfr_pkg::CNT_W'(1): chn_ok_nxt = (rx_byte == channel_code);
            fdfr_pkg::CNT_W'(2): len_nxt    = rx_byte;
            fdfr_pkg::CNT_W'(3): cmd_nxt    = rx_byte;
            fdfr_pkg::CNT_W'(4): arg_nxt    = rx_byte;
            default: ;
          endcase
          cnt_nxt = cnt_r + fdfr_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r    <= crc_nxt;
    older_r  <= older_nxt;
    newer_r  <= newer_nxt;
    dir_ok_r <= dir_ok_nxt;
    chn_ok_r <= chn_ok_nxt;
    len_r    <= len_nxt;
    cmd_r    <= cmd_nxt;
    arg_r    <= arg_nxt;
  end

endmodule

// File: hdl/flag_delimited_frame_receiver_crc16.sv
// ----------------------------------------------------------------------------
// flag_delimited_frame_receiver_crc16
// Receives bytes, finds 0x7E-delimited frames, checks them and reports one
// result per closing flag.
// ----------------------------------------------------------------------------
// Path: each byte is registered in the input stage, and a closing flag's result
// is registered in the output stage when that flag advances out of the input stage.
// Throughput: one byte per cycle while no closing flag's result is held back by a
// waiting result with out_ready low; the one-byte CRC update acts on frame state.
// Reset: synchronous active-low rst_n clears the pipeline valids, the in-frame
// flag and the byte count, and loads direction_code 0 and channel_code 1.
module flag_delimited_frame_receiver_crc16 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [7:0] out_command,
  output logic [7:0] out_argument,
  output logic [5:0] out_payload_length,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic           s1_valid_r, s1_valid_nxt;
  logic [7:0]     s1_byte_r;
  logic           out_valid_r, out_valid_nxt;
  fdfr_pkg::res_t out_res_r;
  logic [7:0]     dir_code_r;
  logic [7:0]     chn_code_r;
  logic           res_valid;
  fdfr_pkg::res_t res;
  logic           slot_free;
  logic           adv;

  assign slot_free = !out_valid_r || out_ready;
  assign adv       = s1_valid_r && (!res_valid || slot_free);
  assign in_ready  = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;

  fdfr_frame u_frame (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (adv),
    .rx_byte        (s1_byte_r),
    .direction_code (dir_code_r),
    .channel_code   (chn_code_r),
    .res_valid      (res_valid),
    .res            (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (adv && res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      dir_code_r  <= 8'd0;
      chn_code_r  <= 8'd1;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && (cfg_index == fdfr_pkg::REG_DIRECTION)) begin
        dir_code_r <= cfg_data;
      end
      if (cfg_valid && (cfg_index == fdfr_pkg::REG_CHANNEL)) begin
        chn_code_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
    if (adv && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_command        = out_res_r.command;
  assign out_argument       = out_res_r.argument;
  assign out_payload_length = out_res_r.payload_length;

  a_err_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.status != fdfr_pkg::ST_OK)
      |-> (out_res_r.command == 8'h00) && (out_res_r.argument == 8'h00))
    else $error("error result carries command or argument");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(adv && res_valid))
    else $error("result overwrites a waiting result");

  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && res_valid && out_valid_r && !out_ready)
    else $error("input stalled without a blocked result");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.status <= fdfr_pkg::ST_LEN_ERR))
    else $error("status code out of range");

endmodule
